// ===== hw/rtl/perceptron_branch_predictor_defines.svh =====
// Assertion macros for the perceptron branch predictor.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef PERCEPTRON_BRANCH_PREDICTOR_DEFINES_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_DEFINES_SVH

`define PBP_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("pbp: invariant violated");

`define PBP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pbp: implication violated");

`define PBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pbp: next-cycle check violated");

`endif

// ===== hw/rtl/pbp_pkg.sv =====
// Package for the perceptron branch predictor: sizes, derived widths, command codes
// and the pending record type. No dependencies.
`default_nettype none
package pbp_pkg;

  localparam int TABLE_ENTRIES  = 163;
  localparam int HISTORY_LENGTH = 24;
  localparam int WEIGHT_BITS    = 8;
  localparam int PENDING_DEPTH  = 16;

  localparam int ADDR_W   = 64;
  localparam int THR_W    = 12;
  localparam int OUT_SUM_W = 13;
  localparam int THR_RESET = 60;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;

  localparam int IDX_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ROW_LEN  = HISTORY_LENGTH + 1;
  localparam int ROW_W    = ROW_LEN * WEIGHT_BITS;

  localparam int LANES    = 8;
  localparam int CHUNKS   = (ROW_LEN + LANES - 1) / LANES;
  localparam int PAD_N    = CHUNKS * LANES;
  localparam int CHK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam int MOD_BITS  = 8;
  localparam int MOD_STEPS = ADDR_W / MOD_BITS;
  localparam int MSTEP_W   = $clog2(MOD_STEPS);

  localparam int SUM_W = $clog2(ROW_LEN * (2 ** (WEIGHT_BITS - 1)) + 1) + 1;
  localparam int EXT_W = (SUM_W > OUT_SUM_W) ? SUM_W : OUT_SUM_W;
  localparam int CMP_W = EXT_W + 1;

  localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);
  localparam int PIDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

  typedef struct packed {
    logic                      pred;
    logic signed [SUM_W-1:0]   sum;
    logic [HISTORY_LENGTH-1:0] hist;
  } pend_rec_t;

endpackage
`default_nettype wire

// ===== hw/rtl/perceptron_branch_predictor.sv =====
// Perceptron branch predictor, top level, with the weight memory inside.
// Depends on pbp_pkg and perceptron_branch_predictor_defines.svh.
// A predict beat passes the address modulo (8 address bits a step), one memory read, a
// load, 4 sum chunks and a finish state; a resolve beat passes the modulo, the read and
// a resolve state. One beat is in work at a time.
// Reset clears histories, pending list and row valid bits and sets the threshold to 60.
`default_nettype none
`include "perceptron_branch_predictor_defines.svh"
module perceptron_branch_predictor
  import pbp_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [THR_W-1:0]            cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        command,
  input  wire logic [ADDR_W-1:0]           branch_address,
  input  wire logic                        taken,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             predict_taken,
  output logic signed [OUT_SUM_W-1:0]      perceptron_sum,
  output logic                             pending_found,
  output logic                             did_train
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MOD  = 7'b0000010,
    ST_READ = 7'b0000100,
    ST_LOAD = 7'b0001000,
    ST_SUM  = 7'b0010000,
    ST_PFIN = 7'b0100000,
    ST_RES  = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [THR_W-1:0]          threshold;
  logic                      cmd_q;
  logic                      taken_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [ADDR_W-1:0]         addr_sh;
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          idx_next;
  logic [MSTEP_W-1:0]        mod_cnt;
  logic [CHK_W-1:0]          chunk_cnt;

  logic [ROW_W-1:0]          wmem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]  row_valid;
  logic [ROW_W-1:0]          rd_row;
  logic                      rd_valid;
  logic [ROW_W-1:0]          row_cur;
  logic [ROW_W-1:0]          row_trained;

  logic [PAD_N*WEIGHT_BITS-1:0] row_sh;
  logic [PAD_N-1:0]             hist_sh;
  logic signed [SUM_W-1:0]      acc;
  logic signed [SUM_W-1:0]      acc_next;

  logic [HISTORY_LENGTH-1:0] spec_hist;
  logic [HISTORY_LENGTH-1:0] real_hist;
  logic [HISTORY_LENGTH-1:0] real_hist_next;

  logic [ADDR_W-1:0]         pa [PENDING_DEPTH];
  pend_rec_t                 pr [PENDING_DEPTH];
  logic [CNT_W-1:0]          count;
  logic [PENDING_DEPTH-1:0]  match_q;
  logic [PIDX_W-1:0]         fidx_sel;
  logic                      found_sel;
  logic [PIDX_W-1:0]         fidx_q;
  logic                      found_q;
  pend_rec_t                 rec_q;

  logic                      go;
  logic                      pred;
  logic signed [EXT_W-1:0]   sum_ext;
  logic signed [OUT_SUM_W-1:0] sum_sat;
  logic signed [CMP_W-1:0]   rec_sum_c;
  logic signed [CMP_W-1:0]   th_c;
  logic                      mispredict;
  logic                      do_train;
  logic                      full;

  assign in_ready = (state == ST_IDLE);
  assign go       = !out_valid || out_ready;
  assign full     = (count == CNT_W'(PENDING_DEPTH));

  always_comb begin
    logic [IDX_W:0] t;
    idx_next = idx;
    for (int b = 0; b < MOD_BITS; b++) begin
      t = {idx_next, addr_sh[ADDR_W-1-b]};
      if (t >= (IDX_W+1)'(TABLE_ENTRIES)) begin
        t = t - (IDX_W+1)'(TABLE_ENTRIES);
      end
      idx_next = t[IDX_W-1:0];
    end
  end

  always_comb begin
    logic signed [WEIGHT_BITS-1:0] w;
    acc_next = acc;
    for (int l = 0; l < LANES; l++) begin
      w = $signed(row_sh[l*WEIGHT_BITS +: WEIGHT_BITS]);
      if (hist_sh[l]) begin
        acc_next = acc_next + SUM_W'(w);
      end else begin
        acc_next = acc_next - SUM_W'(w);
      end
    end
  end

  always_comb begin
    fidx_sel  = '0;
    found_sel = 1'b0;
    for (int k = PENDING_DEPTH - 1; k >= 0; k--) begin
      if (match_q[k]) begin
        fidx_sel  = PIDX_W'(k);
        found_sel = 1'b1;
      end
    end
  end

  assign row_cur = rd_valid ? rd_row : '0;

  always_comb begin
    logic [ROW_LEN-1:0] ext;
    logic signed [WEIGHT_BITS-1:0] w;
    logic up;
    ext = {rec_q.hist, 1'b1};
    row_trained = row_cur;
    for (int i = 0; i < ROW_LEN; i++) begin
      w  = $signed(row_cur[i*WEIGHT_BITS +: WEIGHT_BITS]);
      up = (ext[i] == taken_q);
      if (up) begin
        row_trained[i*WEIGHT_BITS +: WEIGHT_BITS] = (w == W_MAX) ? w : w + 1'b1;
      end else begin
        row_trained[i*WEIGHT_BITS +: WEIGHT_BITS] = (w == W_MIN) ? w : w - 1'b1;
      end
    end
  end

  assign pred    = (acc >= 0);
  assign sum_ext = EXT_W'(acc);
  always_comb begin
    if (sum_ext > EXT_W'(2 ** (OUT_SUM_W - 1) - 1)) begin
      sum_sat = {1'b0, {(OUT_SUM_W-1){1'b1}}};
    end else if (sum_ext < -EXT_W'(2 ** (OUT_SUM_W - 1))) begin
      sum_sat = {1'b1, {(OUT_SUM_W-1){1'b0}}};
    end else begin
      sum_sat = sum_ext[OUT_SUM_W-1:0];
    end
  end

  assign rec_sum_c      = CMP_W'(rec_q.sum);
  assign th_c           = $signed({{(CMP_W-THR_W){1'b0}}, threshold});
  assign mispredict     = (rec_q.pred != taken_q);
  assign do_train       = mispredict || ((rec_sum_c <= th_c) && (rec_sum_c >= -th_c));
  assign real_hist_next = {real_hist[HISTORY_LENGTH-2:0], taken_q};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_MOD;
      ST_MOD:  if (mod_cnt == MSTEP_W'(MOD_STEPS - 1)) state_next = ST_READ;
      ST_READ: state_next = (cmd_q == CMD_RESOLVE) ? ST_RES : ST_LOAD;
      ST_LOAD: state_next = ST_SUM;
      ST_SUM:  if (chunk_cnt == CHK_W'(CHUNKS - 1)) state_next = ST_PFIN;
      ST_PFIN: if (go) state_next = ST_IDLE;
      ST_RES:  if (go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      threshold <= THR_W'(THR_RESET);
      row_valid <= '0;
      spec_hist <= '0;
      real_hist <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if ((state == ST_PFIN || state == ST_RES) && go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_PFIN && go) begin
        spec_hist <= {spec_hist[HISTORY_LENGTH-2:0], pred};
        if (full) begin
          count <= count;
        end else begin
          count <= count + 1'b1;
        end
      end
      if (state == ST_RES && go) begin
        if (found_q) begin
          count     <= count - 1'b1;
          real_hist <= real_hist_next;
          if (mispredict) begin
            spec_hist <= real_hist_next;
          end
          if (do_train) begin
            row_valid[idx] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_row   <= wmem[idx];
      rd_valid <= row_valid[idx];
    end
    if (state == ST_RES && go && found_q && do_train) begin
      wmem[idx] <= row_trained;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd_q   <= command;
        taken_q <= taken;
        addr_q  <= branch_address;
        addr_sh <= branch_address;
        idx     <= '0;
        mod_cnt <= '0;
      end
      ST_MOD: begin
        idx     <= idx_next;
        addr_sh <= addr_sh << MOD_BITS;
        mod_cnt <= mod_cnt + 1'b1;
        for (int k = 0; k < PENDING_DEPTH; k++) begin
          match_q[k] <= (CNT_W'(k) < count) && (pa[k] == addr_q);
        end
      end
      ST_READ: begin
        found_q <= found_sel;
        fidx_q  <= fidx_sel;
        rec_q   <= pr[fidx_sel];
      end
      ST_LOAD: begin
        row_sh    <= (PAD_N*WEIGHT_BITS)'(row_cur);
        hist_sh   <= PAD_N'({spec_hist, 1'b1});
        acc       <= '0;
        chunk_cnt <= '0;
      end
      ST_SUM: begin
        acc       <= acc_next;
        row_sh    <= row_sh >> (LANES * WEIGHT_BITS);
        hist_sh   <= hist_sh >> LANES;
        chunk_cnt <= chunk_cnt + 1'b1;
      end
      default: begin
      end
    endcase

    if (state == ST_PFIN && go) begin
      predict_taken  <= pred;
      perceptron_sum <= sum_sat;
      pending_found  <= 1'b0;
      did_train      <= 1'b0;
      if (full) begin
        for (int k = 0; k < PENDING_DEPTH - 1; k++) begin
          pa[k] <= pa[k+1];
          pr[k] <= pr[k+1];
        end
        pa[PENDING_DEPTH-1] <= addr_q;
        pr[PENDING_DEPTH-1] <= '{pred: pred, sum: acc, hist: spec_hist};
      end else begin
        pa[count[PIDX_W-1:0]] <= addr_q;
        pr[count[PIDX_W-1:0]] <= '{pred: pred, sum: acc, hist: spec_hist};
      end
    end

    if (state == ST_RES && go) begin
      predict_taken  <= 1'b0;
      perceptron_sum <= '0;
      pending_found  <= found_q;
      did_train      <= found_q && do_train;
      if (found_q) begin
        for (int k = 0; k < PENDING_DEPTH - 1; k++) begin
          if (k >= int'(fidx_q)) begin
            pa[k] <= pa[k+1];
            pr[k] <= pr[k+1];
          end
        end
      end
    end
  end

  `PBP_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(PENDING_DEPTH))
  `PBP_ASSERT_NEXT(a_one_beat, in_valid && in_ready, !in_ready)
  `PBP_ASSERT_IMPL(a_train_needs_match, out_valid && did_train, pending_found)
  `PBP_ASSERT_IMPL(a_resolve_clean, out_valid && pending_found, !predict_taken && perceptron_sum == 0)

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the perceptron branch predictor: random and directed
// predict/resolve beats, a scoreboard driven by an independent behavioral predictor.
// Depends on pbp_pkg and perceptron_branch_predictor.
module testbench
  import pbp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WMAXI = (1 << (WEIGHT_BITS - 1)) - 1;
  localparam int WMINI = -WMAXI - 1;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic              tk;
  } branch_beat_t;

  typedef struct {
    logic                        pt;
    logic signed [OUT_SUM_W-1:0] ps;
    logic                        pf;
    logic                        dt;
  } branch_result_t;

  typedef struct {
    logic [ADDR_W-1:0]         addr;
    logic                      pred;
    int                        sum;
    logic [HISTORY_LENGTH-1:0] hist;
  } inflight_branch_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = 1'b0;
  logic [ADDR_W-1:0] branch_address = '0;
  logic taken = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic predict_taken;
  logic signed [OUT_SUM_W-1:0] perceptron_sum;
  logic pending_found;
  logic did_train;

  perceptron_branch_predictor uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .branch_address(branch_address), .taken(taken),
    .out_valid(out_valid), .out_ready(out_ready),
    .predict_taken(predict_taken), .perceptron_sum(perceptron_sum),
    .pending_found(pending_found), .did_train(did_train)
  );

  always #10 clk = ~clk;

  branch_beat_t beat_queue[$];
  branch_result_t expected_results[$];
  int weights[TABLE_ENTRIES][ROW_LEN];
  logic [HISTORY_LENGTH-1:0] spec_hist;
  logic [HISTORY_LENGTH-1:0] real_hist;
  inflight_branch_t inflight[$];
  int theta;
  int error_count = 0;
  int cycle_count = 0;
  bit hold_off = 1'b0;
  bit in_fire = 1'b0;
  bit calm_phase = 1'b0;
  bit stimulus_done = 1'b0;

  function automatic int step_weight(int w, bit up);
    if (up) return (w < WMAXI) ? w + 1 : WMAXI;
    return (w > WMINI) ? w - 1 : WMINI;
  endfunction

  function automatic branch_result_t model_beat(branch_beat_t b);
    branch_result_t r;
    inflight_branch_t rec;
    int row;
    int s;
    int k;
    int so;
    r = '{pt: 1'b0, ps: '0, pf: 1'b0, dt: 1'b0};
    row = int'(b.addr % ADDR_W'(TABLE_ENTRIES));
    if (b.cmd == CMD_PREDICT) begin
      s = weights[row][0];
      for (int i = 0; i < HISTORY_LENGTH; i++) begin
        if (spec_hist[i]) s += weights[row][i+1];
        else s -= weights[row][i+1];
      end
      rec.addr = b.addr;
      rec.pred = (s >= 0);
      rec.sum = s;
      rec.hist = spec_hist;
      if (inflight.size() >= PENDING_DEPTH) inflight.delete(0);
      inflight.insert(inflight.size(), rec);
      spec_hist = {spec_hist[HISTORY_LENGTH-2:0], rec.pred};
      so = (s > 4095) ? 4095 : ((s < -4096) ? -4096 : s);
      r.pt = rec.pred;
      r.ps = OUT_SUM_W'(so);
    end else begin
      k = -1;
      for (int i = 0; i < inflight.size(); i++) begin
        if (k < 0 && inflight[i].addr == b.addr) k = i;
      end
      if (k >= 0) begin
        rec = inflight[k];
        inflight.delete(k);
        real_hist = {real_hist[HISTORY_LENGTH-2:0], b.tk};
        if (rec.pred != b.tk) spec_hist = real_hist;
        r.pf = 1'b1;
        if ((rec.sum <= theta && rec.sum >= -theta) || rec.pred != b.tk) begin
          weights[row][0] = step_weight(weights[row][0], b.tk);
          for (int i = 0; i < HISTORY_LENGTH; i++)
            weights[row][i+1] = step_weight(weights[row][i+1], rec.hist[i] == b.tk);
          r.dt = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire) begin
        expected_results.insert(expected_results.size(),
                                model_beat('{command, branch_address, taken}));
        beat_queue.delete(0);
      end
      if ((!in_valid || in_fire) && beat_queue.size() > 0 &&
          (calm_phase || $urandom_range(99) >= 28)) begin
        in_valid <= 1'b1;
        command <= beat_queue[0].cmd;
        branch_address <= beat_queue[0].addr;
        taken <= beat_queue[0].tk;
      end else if (in_fire) begin
        in_valid <= 1'b0;
      end
      out_ready <= !hold_off && (calm_phase || ($urandom_range(99) >= 28));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_fire <= !rst && in_valid && in_ready;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        error_count++;
      end else begin
        branch_result_t e;
        e = expected_results[0];
        expected_results.delete(0);
        if (e.pt !== predict_taken || e.ps !== perceptron_sum ||
            e.pf !== pending_found || e.dt !== did_train) begin
          $display("%0t: expected pt=%0b sum=%0d found=%0b train=%0b, got %0b %0d %0b %0b",
                   $time, e.pt, e.ps, e.pf, e.dt, predict_taken, perceptron_sum,
                   pending_found, did_train);
          error_count++;
        end
      end
    end
  end

  task automatic drain();
    while (beat_queue.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_theta(int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= THR_W'(value);
    theta = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_beat(logic cmd, logic [ADDR_W-1:0] a, logic t);
    beat_queue.insert(beat_queue.size(), '{cmd, a, t});
  endtask

  task automatic random_phase(int n);
    logic [ADDR_W-1:0] pool[8];
    logic [ADDR_W-1:0] a;
    for (int i = 0; i < 8; i++) pool[i] = {$urandom, $urandom};
    for (int i = 0; i < n; i++) begin
      a = pool[$urandom_range(7)];
      if ($urandom_range(9) == 0) a = {$urandom, $urandom};
      add_beat($urandom_range(1) ? CMD_RESOLVE : CMD_PREDICT, a, $urandom_range(3) != 0);
    end
  endtask

  initial begin
    foreach (weights[i, j]) weights[i][j] = 0;
    spec_hist = '0;
    real_hist = '0;
    theta = THR_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_beat(CMD_PREDICT, '0, 1'b0);
    add_beat(CMD_PREDICT, '1, 1'b1);
    add_beat(CMD_RESOLVE, 64'd5, 1'b1);
    add_beat(CMD_RESOLVE, '0, 1'b0);
    add_beat(CMD_RESOLVE, '1, 1'b1);
    for (int i = 0; i < 18; i++) add_beat(CMD_PREDICT, 64'd163 * i, 1'b0);
    add_beat(CMD_RESOLVE, 64'd0, 1'b1);
    add_beat(CMD_RESOLVE, 64'd326, 1'b0);
    drain();

    write_theta(0);
    random_phase(450);
    drain();
    write_theta(4095);
    random_phase(450);
    fork
      begin
        repeat (40) @(posedge clk);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    drain();
    write_theta($urandom_range(4095));
    calm_phase = 1'b1;
    random_phase(300);
    drain();
    calm_phase = 1'b0;
    write_theta(THR_RESET);
    random_phase(650);
    drain();

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
